// File: hw/rtl/pvkf_pkg.sv
`default_nettype none
package pvkf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_VAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_VAR   = 1'd1;
    localparam logic [CFG_DATA_W-1:0] CFG_VAR_RESET = 32'h0001_0000;

    // result status codes
    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_INIT    = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;
    localparam logic [1:0] ST_ZERO    = 2'd3;

    // microprogram layout
    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_INIT    = 6'd0;
    localparam logic [PC_W-1:0] PC_UPD     = 6'd8;
    localparam logic [PC_W-1:0] PC_OUT_UPD = 6'd52;
    localparam logic [PC_W-1:0] PC_LAST    = 6'd53;

    typedef enum logic [3:0] {
        OP_CLR, OP_CVT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_OUT, OP_BRZ, OP_END
    } t_op;

    // scratch register file entries
    typedef enum logic [4:0] {
        R_POS, R_VEL, R_PP, R_PV, R_VP, R_VV, R_DT, R_DT2, R_DT3, R_DT4,
        R_A, R_AV, R_PVAR, R_MP, R_INC, R_S, R_K1, R_K2, R_DP, R_T0, R_T1
    } t_reg;

    // conversion sources (input/config -> state format)
    typedef enum logic [2:0] {
        CV_MP, CV_DT, CV_AV, CV_PV, CV_A
    } t_cvt;

    typedef struct packed {
        t_op        op;
        t_reg       dst;
        t_reg       sa;
        t_reg       sb;
        t_cvt       cvt;
        logic [1:0] extra;   // extra right shift of a product
        logic       setz;    // record zero flag of the result
        logic       ovf_en;  // saturation of a conversion counts toward status
    } t_uop;

    typedef struct packed {
        logic start;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic zero;
        logic initialized;
    } t_dp_stat;

    typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT} t_ctl_state;

    typedef enum logic [2:0] {DP_IDLE, DP_EXEC, DP_MUL, DP_DIV, DP_SAT} t_dp_phase;

    function automatic t_uop mk(input t_op op, input t_reg d, input t_reg a, input t_reg b,
                                input t_cvt c, input logic [1:0] x, input logic z,
                                input logic ov);
        t_uop u;
        u.op     = op;
        u.dst    = d;
        u.sa     = a;
        u.sb     = b;
        u.cvt    = c;
        u.extra  = x;
        u.setz   = z;
        u.ovf_en = ov;
        return u;
    endfunction

    function automatic t_uop alu(input t_op op, input t_reg d, input t_reg a, input t_reg b,
                                 input logic [1:0] x);
        return mk(op, d, a, b, CV_MP, x, 1'b0, 1'b1);
    endfunction

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(OP_END, R_T0, R_T0, R_T0, CV_MP, 2'd0, 1'b0, 1'b0);
        unique case (pc)
            // initialization
            6'd0:  u = mk(OP_CVT, R_POS, R_T0, R_T0, CV_MP, 2'd0, 1'b0, 1'b0);
            6'd1:  u = alu(OP_CLR, R_VEL, R_T0, R_T0, 2'd0);
            6'd2:  u = alu(OP_CLR, R_PP, R_T0, R_T0, 2'd0);
            6'd3:  u = alu(OP_CLR, R_PV, R_T0, R_T0, 2'd0);
            6'd4:  u = alu(OP_CLR, R_VP, R_T0, R_T0, 2'd0);
            6'd5:  u = alu(OP_CLR, R_VV, R_T0, R_T0, 2'd0);
            6'd6:  u = mk(OP_OUT, R_T0, R_POS, R_VEL, CV_MP, 2'd0, 1'b0, 1'b0);
            6'd7:  u = mk(OP_END, R_T0, R_T0, R_T0, CV_MP, 2'd0, 1'b0, 1'b0);
            // update: operand conversion
            6'd8:  u = mk(OP_CVT, R_MP, R_T0, R_T0, CV_MP, 2'd0, 1'b0, 1'b0);
            6'd9:  u = mk(OP_CVT, R_DT, R_T0, R_T0, CV_DT, 2'd0, 1'b0, 1'b1);
            6'd10: u = mk(OP_CVT, R_AV, R_T0, R_T0, CV_AV, 2'd0, 1'b0, 1'b1);
            6'd11: u = mk(OP_CVT, R_PVAR, R_T0, R_T0, CV_PV, 2'd0, 1'b0, 1'b1);
            6'd12: u = mk(OP_CVT, R_A, R_T0, R_T0, CV_A, 2'd0, 1'b0, 1'b1);
            // powers of dt
            6'd13: u = alu(OP_MUL, R_DT2, R_DT, R_DT, 2'd0);
            6'd14: u = alu(OP_MUL, R_DT3, R_DT2, R_DT, 2'd0);
            6'd15: u = alu(OP_MUL, R_DT4, R_DT3, R_DT, 2'd0);
            // state prediction
            6'd16: u = alu(OP_MUL, R_T0, R_DT, R_VEL, 2'd0);
            6'd17: u = alu(OP_MUL, R_T1, R_DT2, R_A, 2'd1);
            6'd18: u = alu(OP_ADD, R_T0, R_T0, R_T1, 2'd0);
            6'd19: u = alu(OP_ADD, R_POS, R_POS, R_T0, 2'd0);
            6'd20: u = alu(OP_MUL, R_T0, R_DT, R_A, 2'd0);
            6'd21: u = alu(OP_ADD, R_VEL, R_VEL, R_T0, 2'd0);
            // covariance prediction
            6'd22: u = alu(OP_MUL, R_T0, R_DT, R_VV, 2'd0);
            6'd23: u = alu(OP_MUL, R_T1, R_DT3, R_AV, 2'd1);
            6'd24: u = alu(OP_ADD, R_INC, R_T0, R_T1, 2'd0);
            6'd25: u = alu(OP_ADD, R_T0, R_PV, R_VP, 2'd0);
            6'd26: u = alu(OP_ADD, R_T0, R_T0, R_INC, 2'd0);
            6'd27: u = alu(OP_MUL, R_T0, R_DT, R_T0, 2'd0);
            6'd28: u = alu(OP_ADD, R_T0, R_PP, R_T0, 2'd0);
            6'd29: u = alu(OP_MUL, R_T1, R_DT4, R_AV, 2'd2);
            6'd30: u = alu(OP_SUB, R_PP, R_T0, R_T1, 2'd0);
            6'd31: u = alu(OP_ADD, R_VP, R_VP, R_INC, 2'd0);
            6'd32: u = alu(OP_ADD, R_PV, R_PV, R_INC, 2'd0);
            6'd33: u = alu(OP_MUL, R_T0, R_DT2, R_AV, 2'd0);
            6'd34: u = alu(OP_ADD, R_VV, R_VV, R_T0, 2'd0);
            // innovation variance, skip correction when zero
            6'd35: u = mk(OP_ADD, R_S, R_PP, R_PVAR, CV_MP, 2'd0, 1'b1, 1'b1);
            6'd36: u = mk(OP_BRZ, R_T0, R_T0, R_T0, CV_MP, 2'd0, 1'b0, 1'b0);
            // gains and correction
            6'd37: u = alu(OP_DIV, R_K1, R_PP, R_S, 2'd0);
            6'd38: u = alu(OP_DIV, R_K2, R_PV, R_S, 2'd0);
            6'd39: u = alu(OP_SUB, R_DP, R_MP, R_POS, 2'd0);
            6'd40: u = alu(OP_MUL, R_T0, R_K1, R_DP, 2'd0);
            6'd41: u = alu(OP_ADD, R_POS, R_POS, R_T0, 2'd0);
            6'd42: u = alu(OP_MUL, R_T0, R_K2, R_DP, 2'd0);
            6'd43: u = alu(OP_ADD, R_VEL, R_VEL, R_T0, 2'd0);
            6'd44: u = alu(OP_MUL, R_T0, R_K2, R_VP, 2'd0);
            6'd45: u = alu(OP_SUB, R_VV, R_VV, R_T0, 2'd0);
            6'd46: u = alu(OP_MUL, R_T0, R_K2, R_PP, 2'd0);
            6'd47: u = alu(OP_SUB, R_PV, R_PV, R_T0, 2'd0);
            6'd48: u = alu(OP_MUL, R_T0, R_K1, R_VP, 2'd0);
            6'd49: u = alu(OP_SUB, R_VP, R_VP, R_T0, 2'd0);
            6'd50: u = alu(OP_MUL, R_T0, R_K1, R_PP, 2'd0);
            6'd51: u = alu(OP_SUB, R_PP, R_PP, R_T0, 2'd0);
            6'd52: u = mk(OP_OUT, R_T0, R_POS, R_VEL, CV_MP, 2'd0, 1'b0, 1'b0);
            default: u = mk(OP_END, R_T0, R_T0, R_T0, CV_MP, 2'd0, 1'b0, 1'b0);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pvkf_ctrl.sv
`default_nettype none
module pvkf_ctrl import pvkf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    input  wire logic     i_restart,
    output logic          o_s_tready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_ctl_state       r_state, n_state;
    logic [PC_W-1:0]  r_pc, n_pc;
    t_uop             uop;

    assign uop = uop_rom(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_pc    <= PC_INIT;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            C_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = C_ISSUE;
                    n_pc    = (i_restart || !i_stat.initialized) ? PC_INIT : PC_UPD;
                end
            end
            C_ISSUE: begin
                unique case (uop.op)
                    OP_END: n_state = C_IDLE;
                    OP_BRZ: n_pc = i_stat.zero ? PC_OUT_UPD : r_pc + 6'd1;
                    default: n_state = C_WAIT;
                endcase
            end
            C_WAIT: begin
                if (i_stat.done) begin
                    n_state = C_ISSUE;
                    n_pc    = r_pc + 6'd1;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready  = (r_state == C_IDLE);
        o_cmd.uop   = uop;
        o_cmd.start = (r_state == C_ISSUE) && (uop.op != OP_END) && (uop.op != OP_BRZ);
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.done |-> r_state == C_WAIT)
        else $error("datapath done outside wait");
    a_accept_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == C_ISSUE &&
                                        (r_pc == PC_INIT || r_pc == PC_UPD)))
        else $error("accepted item did not start a program");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != C_IDLE |-> r_pc <= PC_LAST)
        else $error("pc ran past program");

endmodule
`default_nettype wire

// File: hw/rtl/pvkf_datapath.sv
`default_nettype none
module pvkf_datapath import pvkf_pkg::*; #(
    parameter int STATE_FRAC_BITS = 32,
    parameter int INPUT_FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic [31:0]           i_sample_time,
    input  wire logic [31:0]           i_measured_position,
    input  wire logic [31:0]           i_measured_accel,
    input  wire logic                  i_restart,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [95:0]                o_m_tdata,
    output logic [1:0]                 o_m_tuser
);

    localparam int CNV_SH    = (STATE_FRAC_BITS >= INPUT_FRAC_BITS) ?
                               STATE_FRAC_BITS - INPUT_FRAC_BITS :
                               INPUT_FRAC_BITS - STATE_FRAC_BITS;
    localparam int DIV_STEPS = 64 + STATE_FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [63:0] val;
        logic        ovf;
    } t_sat64;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } t_sat32;

    // magnitude -> signed 64 with saturation
    function automatic t_sat64 sat_mag(input logic neg, input logic [127:0] v);
        t_sat64 r;
        if (neg) begin
            if (v[127:64] != '0 || v[63:0] > 64'h8000_0000_0000_0000) begin
                r.val = 64'h8000_0000_0000_0000;
                r.ovf = 1'b1;
            end else begin
                r.val = ~v[63:0] + 64'd1;
                r.ovf = 1'b0;
            end
        end else if (v[127:63] != '0) begin
            r.val = 64'h7FFF_FFFF_FFFF_FFFF;
            r.ovf = 1'b1;
        end else begin
            r.val = v[63:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    // state format -> output format, truncate toward zero, saturate
    function automatic t_sat32 from_state(input logic [63:0] x);
        t_sat32        r;
        logic [127:0]  v;
        v = (STATE_FRAC_BITS >= INPUT_FRAC_BITS) ? ({64'd0, mag64(x)} >> CNV_SH)
                                                 : ({64'd0, mag64(x)} << CNV_SH);
        if (x[63]) begin
            if (v[127:64] != '0 || v[63:0] > 64'h0000_0000_8000_0000) begin
                r.val = 32'h8000_0000;
                r.ovf = 1'b1;
            end else begin
                r.val = ~v[31:0] + 32'd1;
                r.ovf = 1'b0;
            end
        end else if (v[127:31] != '0) begin
            r.val = 32'h7FFF_FFFF;
            r.ovf = 1'b1;
        end else begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    logic [63:0]     r_mem [32];
    logic [63:0]     r_opa, r_opb;

    t_dp_phase       r_phase;
    t_uop            r_uop;
    logic [31:0]     r_av, r_pvar;
    logic [31:0]     r_last_time, r_dt_raw, r_mp_raw, r_acc_raw;
    logic            r_is_init, r_init_item, r_ovf, r_zero;
    logic [127:0]    r_acc;
    logic [63:0]     r_ma, r_mb, r_rem;
    logic            r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic            r_out_valid;
    logic [31:0]     r_out_pos, r_out_vel, r_out_acc;
    logic [1:0]      r_out_status;

    logic            wr_en, wr_ovf, done, out_load;
    logic [63:0]     wr_data;
    logic [31:0]     cv_raw, cv_mag;
    logic            cv_neg;
    logic [127:0]    cv_wide;
    t_sat64          cv_res, sm_res;
    logic [63:0]     as_val;
    logic            as_ovf;
    logic [31:0]     pa, pb;
    logic [63:0]     prod;
    logic [1:0]      pp_pos;
    logic [127:0]    pp_sh, acc_next, sat_in;
    logic [64:0]     rem2;
    logic            q_bit;
    logic [63:0]     rem_next;
    t_sat32          fs_pos, fs_vel;
    logic [1:0]      out_status;

    // operand conversion into state format
    always_comb begin
        unique case (r_uop.cvt)
            CV_MP:   begin cv_raw = r_mp_raw;  cv_neg = r_mp_raw[31];  end
            CV_DT:   begin cv_raw = r_dt_raw;  cv_neg = 1'b0;          end
            CV_AV:   begin cv_raw = r_av;      cv_neg = 1'b0;          end
            CV_PV:   begin cv_raw = r_pvar;    cv_neg = 1'b0;          end
            CV_A:    begin cv_raw = r_acc_raw; cv_neg = r_acc_raw[31]; end
            default: begin cv_raw = r_dt_raw;  cv_neg = 1'b0;          end
        endcase
        cv_mag  = cv_neg ? (~cv_raw + 32'd1) : cv_raw;
        cv_wide = (STATE_FRAC_BITS >= INPUT_FRAC_BITS) ? ({96'd0, cv_mag} << CNV_SH)
                                                       : ({96'd0, cv_mag} >> CNV_SH);
        cv_res  = sat_mag(cv_neg, cv_wide);
    end

    // saturating add / subtract
    always_comb begin
        if (r_uop.op == OP_SUB) begin
            as_val = r_opa - r_opb;
            as_ovf = (r_opa[63] != r_opb[63]) && (as_val[63] != r_opa[63]);
        end else begin
            as_val = r_opa + r_opb;
            as_ovf = (r_opa[63] == r_opb[63]) && (as_val[63] != r_opa[63]);
        end
        if (as_ovf) as_val = r_opa[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end

    // one 32x32 partial product per cycle
    always_comb begin
        pa     = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
        pb     = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
        prod   = pa * pb;
        pp_pos = {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
        unique case (pp_pos)
            2'd0:    pp_sh = {64'd0, prod};
            2'd1:    pp_sh = {32'd0, prod, 32'd0};
            default: pp_sh = {prod, 64'd0};
        endcase
        acc_next = r_acc + pp_sh;
    end

    // one restoring divide step per cycle
    always_comb begin
        rem2     = {r_rem, r_ma[63]};
        q_bit    = rem2 >= {1'b0, r_mb};
        rem_next = q_bit ? 64'(rem2 - {1'b0, r_mb}) : rem2[63:0];
    end

    // product scaling and final saturation
    always_comb begin
        if (r_uop.op == OP_DIV) begin
            sat_in = r_acc;
        end else begin
            unique case (r_uop.extra)
                2'd0:    sat_in = r_acc >> STATE_FRAC_BITS;
                2'd1:    sat_in = r_acc >> (STATE_FRAC_BITS + 1);
                default: sat_in = r_acc >> (STATE_FRAC_BITS + 2);
            endcase
        end
        sm_res = sat_mag(r_neg, sat_in);
    end

    always_comb begin
        fs_pos = from_state(r_opa);
        fs_vel = from_state(r_opb);
        priority if (r_init_item)                      out_status = ST_INIT;
        else if (r_zero)                               out_status = ST_ZERO;
        else if (r_ovf || fs_pos.ovf || fs_vel.ovf)    out_status = ST_SAT;
        else                                           out_status = ST_UPDATED;
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_data  = '0;
        wr_ovf   = 1'b0;
        done     = 1'b0;
        out_load = 1'b0;
        unique case (r_phase)
            DP_EXEC: begin
                unique case (r_uop.op)
                    OP_CLR: begin
                        wr_en = 1'b1;
                        done  = 1'b1;
                    end
                    OP_CVT: begin
                        wr_en   = 1'b1;
                        wr_data = cv_res.val;
                        wr_ovf  = cv_res.ovf & r_uop.ovf_en;
                        done    = 1'b1;
                    end
                    OP_ADD, OP_SUB: begin
                        wr_en   = 1'b1;
                        wr_data = as_val;
                        wr_ovf  = as_ovf;
                        done    = 1'b1;
                    end
                    OP_OUT: begin
                        if (!r_out_valid || i_m_tready) begin
                            out_load = 1'b1;
                            done     = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            DP_SAT: begin
                wr_en   = 1'b1;
                wr_data = sm_res.val;
                wr_ovf  = sm_res.ovf;
                done    = 1'b1;
            end
            default: ;
        endcase
    end

    // scratch file: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_uop.dst] <= wr_data;
        if (i_cmd.start) begin
            r_opa <= r_mem[i_cmd.uop.sa];
            r_opb <= r_mem[i_cmd.uop.sb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= DP_IDLE;
            r_av        <= CFG_VAR_RESET;
            r_pvar      <= CFG_VAR_RESET;
            r_last_time <= '0;
            r_acc_raw   <= '0;
            r_is_init   <= 1'b0;
            r_init_item <= 1'b0;
            r_ovf       <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ACCEL_VAR: r_av   <= i_cfg_data;
                    CFG_POS_VAR:   r_pvar <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_accept) begin
                r_dt_raw    <= i_sample_time - r_last_time;
                r_last_time <= i_sample_time;
                r_mp_raw    <= i_measured_position;
                r_acc_raw   <= i_measured_accel;
                r_init_item <= i_restart || !r_is_init;
                r_is_init   <= 1'b1;
                r_ovf       <= 1'b0;
            end else if (wr_en) begin
                r_ovf <= r_ovf | wr_ovf;
            end

            if (wr_en && r_uop.setz) r_zero <= (wr_data == '0);

            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_pos    <= fs_pos.val;
                r_out_vel    <= fs_vel.val;
                r_out_acc    <= r_acc_raw;
                r_out_status <= out_status;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_phase)
                DP_IDLE: begin
                    if (i_cmd.start) begin
                        r_uop   <= i_cmd.uop;
                        r_phase <= DP_EXEC;
                    end
                end
                DP_EXEC: begin
                    if (r_uop.op == OP_MUL || r_uop.op == OP_DIV) begin
                        r_ma    <= mag64(r_opa);
                        r_mb    <= mag64(r_opb);
                        r_neg   <= r_opa[63] ^ r_opb[63];
                        r_acc   <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_phase <= (r_uop.op == OP_MUL) ? DP_MUL : DP_DIV;
                    end else if (done) begin
                        r_phase <= DP_IDLE;
                    end
                end
                DP_MUL: begin
                    r_acc <= acc_next;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(3)) r_phase <= DP_SAT;
                end
                DP_DIV: begin
                    r_rem <= rem_next;
                    r_ma  <= {r_ma[62:0], 1'b0};
                    r_acc <= {r_acc[126:0], q_bit};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) r_phase <= DP_SAT;
                end
                DP_SAT:  r_phase <= DP_IDLE;
                default: r_phase <= DP_IDLE;
            endcase
        end
    end

    assign o_stat.done        = done;
    assign o_stat.zero        = r_zero;
    assign o_stat.initialized = r_is_init;
    assign o_m_tvalid         = r_out_valid;
    assign o_m_tdata          = {r_out_acc, r_out_vel, r_out_pos};
    assign o_m_tuser          = r_out_status;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_phase == DP_IDLE)
        else $error("op started while datapath busy");
    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == DP_MUL |-> r_cnt < CNT_W'(4))
        else $error("multiply step count out of range");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten");

endmodule
`default_nettype wire

// File: hw/rtl/position_velocity_kalman_filter_top.sv
// Channel   Dir  Signals                      Contents (low bit first)
// s         in   i_s_tvalid/o_s_tready        tdata: sample_time, measured_position,
//                                             measured_accel; tuser: restart
// m         out  o_m_tvalid/i_m_tready        tdata: est_position, est_velocity,
//                                             est_accel; tuser: status
// cfg       in   i_cfg_we/i_cfg_addr/data     0 accel_variance, 1 position_variance
//
// One item at a time, run by a microprogram of convert/add/sub/clear micro-ops,
// multiplies built from four 32x32 partial products and bit-serial restoring divides.
// An update item skips the gains and the correction when the innovation variance is zero.
// Reset (synchronous, active low) clears the filter to uninitialized and both
// variances to 1.0. A held result stalls only the final output step; after the
// result is loaded into o_m, the sequencer issues its end micro-op and returns to
// idle, where the next item is accepted.
`default_nettype none
module position_velocity_kalman_filter_top import pvkf_pkg::*; #(
    parameter int STATE_FRAC_BITS = 32,
    parameter int INPUT_FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [95:0]           i_s_tdata,   // sample_time, measured_position, measured_accel
    input  wire logic                  i_s_tuser,   // restart
    // result items
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [95:0]                o_m_tdata,   // est_position, est_velocity, est_accel
    output logic [1:0]                 o_m_tuser,   // status
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     s_accept;

    assign s_accept = i_s_tvalid & o_s_tready;

    // sequencer: picks init or update program, steps through micro-ops
    pvkf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_restart  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // filter state, arithmetic units and the result register
    pvkf_datapath #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS),
        .INPUT_FRAC_BITS (INPUT_FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_data          (i_cfg_data),
        .i_accept            (s_accept),
        .i_sample_time       (i_s_tdata[31:0]),
        .i_measured_position (i_s_tdata[63:32]),
        .i_measured_accel    (i_s_tdata[95:64]),
        .i_restart           (i_s_tuser),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_m_tvalid          (o_m_tvalid),
        .i_m_tready          (i_m_tready),
        .o_m_tdata           (o_m_tdata),
        .o_m_tuser           (o_m_tuser)
    );

endmodule
`default_nettype wire
